// ===== src/bll_pkg.sv =====
// ----------------------------------------------------------------------------
// bll_pkg
// Shared types for the line rasterizer: request and pixel beats, core status.
// ----------------------------------------------------------------------------
`default_nettype none

package bll_pkg;

    localparam int unsigned COORD_W = 8;
    localparam int unsigned ERR_W   = COORD_W + 1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ERR_W-1:0]   err_t;

    typedef enum logic
    {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        logic      color;
        coord_t    y_end;
        coord_t    x_end;
        coord_t    y_start;
        coord_t    x_start;
        req_kind_t req_type;
    } req_t;

    typedef struct packed
    {
        logic   last;
        logic   pixel_color;
        logic   on_screen;
        coord_t pixel_y;
        coord_t pixel_x;
    } pix_t;

    typedef struct packed
    {
        logic active;
        logic steep;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/bll_core.sv =====
// ----------------------------------------------------------------------------
// bll_core
// Line state; one Bresenham iteration per active-line step.
// ----------------------------------------------------------------------------
`default_nettype none

module bll_core #(
    parameter int unsigned SCREEN_W = 128,
    parameter int unsigned SCREEN_H = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_en,
    input  wire bll_pkg::req_t req,
    output logic               emit,
    output bll_pkg::pix_t      pix,
    output bll_pkg::stat_t     stat
);

    logic            active_reg,      active_next;
    logic            steep_reg,       steep_next;
    bll_pkg::coord_t major_pos_reg,   major_pos_next;
    bll_pkg::coord_t major_end_reg,   major_end_next;
    bll_pkg::coord_t minor_pos_reg,   minor_pos_next;
    logic            minor_down_reg,  minor_down_next;
    bll_pkg::err_t   err_acc_reg,     err_acc_next;
    bll_pkg::coord_t delta_major_reg, delta_major_next;
    bll_pkg::coord_t delta_minor_reg, delta_minor_next;
    logic            line_color_reg,  line_color_next;

    // start path
    bll_pkg::coord_t dx, dy;
    logic            st_steep;
    bll_pkg::coord_t ma, na, mb, nb;
    logic            swap;
    bll_pkg::coord_t s_ma, s_na, s_mb, s_nb;

    // step path
    bll_pkg::coord_t px, py;
    logic            is_last;
    bll_pkg::err_t   err_sub;

    assign dx       = (req.x_start > req.x_end) ? (req.x_start - req.x_end)
                                                : (req.x_end - req.x_start);
    assign dy       = (req.y_start > req.y_end) ? (req.y_start - req.y_end)
                                                : (req.y_end - req.y_start);
    assign st_steep = dy > dx;
    assign ma       = st_steep ? req.y_start : req.x_start;
    assign na       = st_steep ? req.x_start : req.y_start;
    assign mb       = st_steep ? req.y_end   : req.x_end;
    assign nb       = st_steep ? req.x_end   : req.y_end;
    assign swap     = ma > mb;
    assign s_ma     = swap ? mb : ma;
    assign s_mb     = swap ? ma : mb;
    assign s_na     = swap ? nb : na;
    assign s_nb     = swap ? na : nb;

    assign px      = steep_reg ? minor_pos_reg : major_pos_reg;
    assign py      = steep_reg ? major_pos_reg : minor_pos_reg;
    assign is_last = major_pos_reg == major_end_reg;
    assign err_sub = err_acc_reg - {1'b0, delta_minor_reg};

    assign emit = req_en && (req.req_type == bll_pkg::REQ_STEP) && active_reg;

    always_comb
    begin
        pix.pixel_x     = px;
        pix.pixel_y     = py;
        pix.on_screen   = ({1'b0, px} < 9'(SCREEN_W)) && ({1'b0, py} < 9'(SCREEN_H));
        pix.pixel_color = line_color_reg;
        pix.last        = is_last;
    end

    assign stat.active = active_reg;
    assign stat.steep  = steep_reg;

    always_comb
    begin
        active_next      = active_reg;
        steep_next       = steep_reg;
        major_pos_next   = major_pos_reg;
        major_end_next   = major_end_reg;
        minor_pos_next   = minor_pos_reg;
        minor_down_next  = minor_down_reg;
        err_acc_next     = err_acc_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        line_color_next  = line_color_reg;
        if (req_en && (req.req_type == bll_pkg::REQ_START))
        begin
            active_next      = 1'b1;
            steep_next       = st_steep;
            major_pos_next   = s_ma;
            major_end_next   = s_mb;
            minor_pos_next   = s_na;
            minor_down_next  = !(s_na < s_nb);
            delta_major_next = s_mb - s_ma;
            delta_minor_next = (s_na > s_nb) ? (s_na - s_nb) : (s_nb - s_na);
            err_acc_next     = {2'b00, delta_major_next[7:1]};
            line_color_next  = req.color;
        end
        else if (emit)
        begin
            err_acc_next = err_sub;
            if (err_sub[bll_pkg::ERR_W-1])
            begin
                minor_pos_next = minor_down_reg ? (minor_pos_reg - 8'd1)
                                                : (minor_pos_reg + 8'd1);
                err_acc_next   = err_sub + {1'b0, delta_major_reg};
            end
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_pos_next = major_pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            major_end_reg   <= '0;
            minor_pos_reg   <= '0;
            minor_down_reg  <= 1'b0;
            err_acc_reg     <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            line_color_reg  <= 1'b0;
        end
        else
        begin
            active_reg      <= active_next;
            steep_reg       <= steep_next;
            major_pos_reg   <= major_pos_next;
            major_end_reg   <= major_end_next;
            minor_pos_reg   <= minor_pos_next;
            minor_down_reg  <= minor_down_next;
            err_acc_reg     <= err_acc_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            line_color_reg  <= line_color_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bresenham_line_rasterizer_top.sv =====
// A step beat sits in the input register, then its pixel in the output register.
// Throughput: 1 request beat per cycle unless a held pixel waits on m_tready.
// Start beats produce no output; steps on an idle line are dropped.
// Reset (rst_n low, async) clears the line state and both beat valid flags.
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top
// Streaming Bresenham line rasterizer: input register, core, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_top #(
    parameter int unsigned SCREEN_W = 128,
    parameter int unsigned SCREEN_H = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], color[32], zero[39:33]
    input  wire logic [39:0] s_tdata,
    // req_type[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_x[7:0], pixel_y[15:8], pixel_color[16], zero[23:17]
    output logic [23:0]      m_tdata,
    // on_screen[0]
    output logic             m_tuser,
    output logic             m_tlast
);

    logic            in_valid_reg;
    bll_pkg::req_t   in_reg;
    bll_pkg::req_t   in_beat;
    logic            advance;
    logic            emit;
    bll_pkg::pix_t   pix;
    bll_pkg::stat_t  stat;
    logic            out_valid_reg;
    bll_pkg::pix_t   out_reg;

    always_comb
    begin
        in_beat.req_type = bll_pkg::req_kind_t'(s_tuser);
        in_beat.x_start  = s_tdata[7:0];
        in_beat.y_start  = s_tdata[15:8];
        in_beat.x_end    = s_tdata[23:16];
        in_beat.y_end    = s_tdata[31:24];
        in_beat.color    = s_tdata[32];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= in_beat;
        end
    end

    bll_core #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_en (advance),
        .req    (in_reg),
        .emit   (emit),
        .pix    (pix),
        .stat   (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.pixel_color, out_reg.pixel_y, out_reg.pixel_x};
    assign m_tuser  = out_reg.on_screen;
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_reg.req_type == bll_pkg::REQ_START) |=> stat.active)
        else $error("start beat did not arm the line");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && pix.last |=> !stat.active)
        else $error("line still active after last pixel");

    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> stat.active && in_valid_reg && advance)
        else $error("pixel emitted without an active line");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("stalled request register changed");
`endif

endmodule

`default_nettype wire

// ===== tb/bresenham_line_rasterizer_top_checker.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_checker
// Watches the request and pixel streams of the line rasterizer, predicts each
// pixel beat from the accepted requests and compares it field by field.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_checker #(
    parameter int unsigned SCREEN_W = 128,
    parameter int unsigned SCREEN_H = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        finished,
    output int          fail_count,
    output int          outstanding,
    output int          pixels_checked,
    output int          pixels_offscreen
);

    timeunit 1ns;
    timeprecision 1ps;

    // line state
    bit              ln_active;
    bit              ln_steep;
    bit              ln_down;
    bit              ln_color;
    bll_pkg::coord_t maj_pos;
    bll_pkg::coord_t maj_end;
    bll_pkg::coord_t min_pos;
    bll_pkg::coord_t d_major;
    bll_pkg::coord_t d_minor;
    logic signed [bll_pkg::ERR_W-1:0] err_term;

    bll_pkg::pix_t   pixel_queue[$];
    bll_pkg::pix_t   next_pix;
    bit              leftover_done;

    initial
    begin
        fail_count       = 0;
        pixels_checked   = 0;
        pixels_offscreen = 0;
        leftover_done    = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < 200)
            $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    function automatic bit rasterize_beat(input bll_pkg::req_t beat, output bll_pkg::pix_t px);
        bll_pkg::coord_t ma;
        bll_pkg::coord_t na;
        bll_pkg::coord_t mb;
        bll_pkg::coord_t nb;
        bll_pkg::coord_t tmp;
        bll_pkg::coord_t dx;
        bll_pkg::coord_t dy;
        px = '0;
        if (beat.req_type == bll_pkg::REQ_START)
        begin
            dx = (beat.x_start > beat.x_end) ? beat.x_start - beat.x_end
                                             : beat.x_end - beat.x_start;
            dy = (beat.y_start > beat.y_end) ? beat.y_start - beat.y_end
                                             : beat.y_end - beat.y_start;
            ln_steep = (dy > dx);
            if (ln_steep)
            begin
                ma = beat.y_start; na = beat.x_start;
                mb = beat.y_end;   nb = beat.x_end;
            end
            else
            begin
                ma = beat.x_start; na = beat.y_start;
                mb = beat.x_end;   nb = beat.y_end;
            end
            if (ma > mb)
            begin
                tmp = ma; ma = mb; mb = tmp;
                tmp = na; na = nb; nb = tmp;
            end
            maj_pos   = ma;
            maj_end   = mb;
            min_pos   = na;
            ln_down   = !(na < nb);
            d_major   = mb - ma;
            d_minor   = (na > nb) ? na - nb : nb - na;
            err_term  = $signed({1'b0, d_major >> 1});
            ln_color  = beat.color;
            ln_active = 1'b1;
            return 1'b0;
        end
        if (!ln_active)
            return 1'b0;

        px.pixel_x     = ln_steep ? min_pos : maj_pos;
        px.pixel_y     = ln_steep ? maj_pos : min_pos;
        px.on_screen   = (32'(px.pixel_x) < SCREEN_W) && (32'(px.pixel_y) < SCREEN_H);
        px.pixel_color = ln_color;
        px.last        = (maj_pos == maj_end);

        err_term = err_term - $signed({1'b0, d_minor});
        if (err_term < 0)
        begin
            min_pos  = ln_down ? min_pos - 1'b1 : min_pos + 1'b1;
            err_term = err_term + $signed({1'b0, d_major});
        end
        if (px.last)
            ln_active = 1'b0;
        else
            maj_pos = maj_pos + 1'b1;
        return 1'b1;
    endfunction

    task automatic check_pixel(input bll_pkg::pix_t got);
        bll_pkg::pix_t want;
        if (pixel_queue.size() == 0)
        begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.pixel_x, got.pixel_y));
            return;
        end
        want = pixel_queue.pop_front();
        if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
        if (got.on_screen !== want.on_screen)
            report_mismatch($sformatf("on_screen got %b want %b at (%0d,%0d)",
                got.on_screen, want.on_screen, want.pixel_x, want.pixel_y));
        if (got.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color got %b want %b at (%0d,%0d)",
                got.pixel_color, want.pixel_color, want.pixel_x, want.pixel_y));
        if (got.last !== want.last)
            report_mismatch($sformatf("last got %b want %b at (%0d,%0d)",
                got.last, want.last, want.pixel_x, want.pixel_y));
        pixels_checked++;
        if (!want.on_screen)
            pixels_offscreen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ln_active = 1'b0;
            ln_steep  = 1'b0;
            ln_down   = 1'b0;
            ln_color  = 1'b0;
            maj_pos   = '0;
            maj_end   = '0;
            min_pos   = '0;
            d_major   = '0;
            d_minor   = '0;
            err_term  = '0;
            pixel_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_pixel({m_tlast, m_tdata[16], m_tuser, m_tdata[15:0]});
            if (s_tvalid && s_tready)
            begin
                if (rasterize_beat(bll_pkg::req_t'({s_tdata[32:0], s_tuser}), next_pix))
                    pixel_queue.push_back(next_pix);
            end
            if (finished && !leftover_done)
            begin
                if (pixel_queue.size() != 0)
                    report_mismatch($sformatf("%0d expected pixels never arrived",
                        pixel_queue.size()));
                leftover_done = 1'b1;
            end
            outstanding <= pixel_queue.size();
        end
    end

endmodule

// ===== tb/bresenham_line_rasterizer_top_test.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_top_test
// Drives start and step requests into the line rasterizer with random idling
// on both streams; a checker beside the block predicts and compares pixels.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCREEN_W     = 128;
    localparam int unsigned SCREEN_H     = 64;
    localparam int          RANDOM_BEATS = 450;
    localparam int          CYCLE_LIMIT  = 200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        finished = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;

    int src_idle  = 32;
    int sink_idle = 49;
    int beats_sent;
    int starts_sent;
    int useful_beats;
    int cycles;
    int fail_count;
    int outstanding;
    int pixels_checked;
    int pixels_offscreen;

    bresenham_line_rasterizer_top #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bresenham_line_rasterizer_top_checker #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .finished         (finished),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .pixels_checked   (pixels_checked),
        .pixels_offscreen (pixels_offscreen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle);
        cycles   <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bll_pkg::req_t random_beat(input bll_pkg::req_kind_t kind);
        logic [63:0]   raw;
        bll_pkg::req_t beat;
        raw           = {$urandom, $urandom};
        beat          = bll_pkg::req_t'(raw[$bits(bll_pkg::req_t)-1:0]);
        beat.req_type = kind;
        return beat;
    endfunction

    function automatic int pick_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 255 : 0;
        return $urandom_range(0, 255);
    endfunction

    function automatic int offset_coord(input int base, input int offs);
        if (base + offs <= 255 && ($urandom_range(0, 1) || base < offs))
            return base + offs;
        if (base >= offs)
            return base - offs;
        return 255;
    endfunction

    task automatic send_beat(input bll_pkg::req_t beat);
        if ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, beat[33:1]};
        s_tuser  <= beat.req_type;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic draw_line(input bll_pkg::coord_t x0, input bll_pkg::coord_t y0,
                             input bll_pkg::coord_t x1, input bll_pkg::coord_t y1,
                             input logic c, input int n_steps);
        bll_pkg::req_t beat;
        beat         = random_beat(bll_pkg::REQ_START);
        beat.x_start = x0;
        beat.y_start = y0;
        beat.x_end   = x1;
        beat.y_end   = y1;
        beat.color   = c;
        send_beat(beat);
        starts_sent++;
        repeat (n_steps) send_beat(random_beat(bll_pkg::REQ_STEP));
    endtask

    task automatic random_line();
        int span;
        int x0;
        int y0;
        int x1;
        int y1;
        int dx;
        int dy;
        int len;
        int n;
        span = ($urandom_range(0, 59) == 0) ? $urandom_range(64, 255) : $urandom_range(0, 12);
        x0   = pick_coord();
        y0   = pick_coord();
        x1   = offset_coord(x0, $urandom_range(0, span));
        y1   = offset_coord(y0, $urandom_range(0, span));
        dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy   = (y1 > y0) ? y1 - y0 : y0 - y1;
        len  = ((dx > dy) ? dx : dy) + 1;
        case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, len - 1);       // abandoned by the next start
            1:       n = len + $urandom_range(1, 3);       // trailing steps on an idle line
            default: n = len;
        endcase
        draw_line(8'(x0), 8'(y0), 8'(x1), 8'(y1), 1'($urandom_range(0, 1)), n);
        useful_beats += 1 + ((n < len) ? n : len);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed
        send_beat(random_beat(bll_pkg::REQ_STEP));          // step with no line loaded
        draw_line(8'd5, 8'd5, 8'd5, 8'd5, 1'b1, 2);         // single point, then idle step
        draw_line(8'd255, 8'd0, 8'd251, 8'd2, 1'b0, 5);     // shallow, endpoints swapped
        draw_line(8'd0, 8'd255, 8'd1, 8'd251, 1'b1, 5);     // steep, minor counts down
        draw_line(8'd200, 8'd10, 8'd203, 8'd10, 1'b1, 2);   // flat line cut short
        draw_line(8'd126, 8'd62, 8'd129, 8'd65, 1'b0, 4);   // crosses both screen edges
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle  <= (ph == 0) ? 32 : (ph == 1) ? 49 : 0;
            sink_idle <= (ph == 0) ? 49 : (ph == 1) ? 32 : 0;
            @(posedge clk);
            target = useful_beats + RANDOM_BEATS / 3;
            while (useful_beats < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_beat(random_beat(bll_pkg::req_kind_t'(1'($urandom_range(0, 1)))));
                    useful_beats++;
                end
                else
                    random_line();
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        finished <= 1'b1;
        repeat (3) @(posedge clk);

        $display("Sent %0d request beats (%0d line starts) under three idle mixes;",
                 beats_sent, starts_sent);
        $display("checked %0d pixels, %0d of them off screen.", pixels_checked, pixels_offscreen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/bll_pkg.sv
src/bll_core.sv
src/bresenham_line_rasterizer_top.sv
tb/bresenham_line_rasterizer_top_checker.sv
tb/bresenham_line_rasterizer_top_test.sv
